// ----- src/audio_compressor_noise_gate_core_assert.svh -----
// Assertion macros for the compressor / noise gate core.
// Included by the top level; no other dependencies.
`ifndef AUDIO_COMPRESSOR_NOISE_GATE_CORE_ASSERT_SVH
`define AUDIO_COMPRESSOR_NOISE_GATE_CORE_ASSERT_SVH
`ifndef SYNTH
`define ACNG_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("acng assertion failed");
`define ACNG_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("acng assertion failed");
`else
`define ACNG_ASSERT(lbl, clk, rstn, prop)
`define ACNG_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ----- src/acng_pkg.sv -----
// Shared constants and types for the compressor / noise gate core.
// No dependencies.
`default_nettype none
package acng_pkg;
	localparam int CHANNELS = 8;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MUL_A_W  = 33;
	localparam int MUL_B_W  = 24;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;

	localparam logic [23:0] ONE_Q23          = 24'h800000;
	localparam logic [23:0] HALF_Q23         = 24'h400000;
	localparam logic [23:0] MAX_POS_Q23      = 24'h7FFFFF;
	localparam logic [23:0] ENV_EPS          = 24'd8;
	localparam logic [18:0] THR_BASE_Q16     = 19'd130624;
	localparam logic [18:0] THR_SPAN_Q16     = 19'd304788;
	localparam logic [14:0] LOG_CORR         = 15'd22282;
	localparam logic [14:0] EXP_CORR         = 15'd22479;
	localparam logic [20:0] TENTH_DB_TO_LOG2 = 21'd1114654;
	localparam logic [18:0] DIV_BASE         = 19'd131072;
	localparam logic [16:0] SLOPE_RESET      = 17'd52429;

	typedef enum logic [2:0] {
		CFG_MODE       = 3'd0,
		CFG_COMP_ATK   = 3'd1,
		CFG_COMP_REL   = 3'd2,
		CFG_GATE_ATK   = 3'd3,
		CFG_GATE_REL   = 3'd4,
		CFG_SUSTAIN    = 3'd5,
		CFG_MAKEUP     = 3'd6,
		CFG_GATE_THR   = 3'd7
	} cfg_idx_t;

	typedef logic [23:0] q23_t;
endpackage
`default_nettype wire

// ----- src/audio_compressor_noise_gate_core.sv -----
// Feedforward peak compressor and noise gate, top level.
// Depends on acng_pkg and audio_compressor_noise_gate_core_assert.svh.
//
// One sample at a time runs through a sequencer around one shared 33x24
// multiplier, one product per cycle. The output takes longest in compressor
// mode when the level is over threshold, less when it is not, and least in
// gate mode. The next sample can be taken, at the earliest, in the cycle
// after the output register loads. A channel out of range passes through
// unprocessed. A stalled output holds the sequencer in its last state until
// the output register frees up. A write of sustain starts the slope
// division; no sample is taken until it completes.
`default_nettype none
module audio_compressor_noise_gate_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         channel,
	input  wire logic signed [23:0] sample_in,
	input  wire logic               block_end,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [23:0]      sample_out,
	output logic [2:0]              channel_out,
	output logic                    block_end_out,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_wdata
);
	`include "audio_compressor_noise_gate_core_assert.svh"

	typedef enum logic [4:0] {
		S_IDLE, S_E1, S_E2, S_E3, S_N16, S_N8, S_N4, S_N2, S_N1,
		S_L1, S_L2, S_L3, S_O1, S_O2, S_GA1, S_GA2, S_XA, S_XB, S_XC,
		S_GT, S_G1, S_G2, S_G3, S_M1, S_M2, S_M3, S_M4, S_DONE
	} state_t;

	// configuration
	logic        mode_q;
	logic [15:0] comp_atk_q, comp_rel_q, gate_atk_q, gate_rel_q, sustain_q, makeup_q;
	logic signed [10:0] gate_thr_q;

	// slope divider
	logic        div_busy_q;
	logic [19:0] div_r_q;
	logic [18:0] div_d_q;
	logic [15:0] div_q_q;
	logic [4:0]  div_cnt_q;
	logic [16:0] slope_q;
	logic [19:0] div_r2;
	logic        div_ge;
	logic [15:0] div_q_next;

	// sequencer and datapath
	state_t      state_q;
	logic [2:0]  ch_q;
	logic [23:0] raw_q, mag_q;
	logic        neg_q, be_q, pass_q;
	acng_pkg::q23_t env_w_q, gain_w_q, tgt_q, a_q, x_q;
	logic [15:0] coef_q, f_q;
	logic [40:0] acc_q;
	logic [acng_pkg::PROD_W-1:0] prod_q;
	logic [4:0]  sh_q, i_q;
	logic [18:0] thr_q;
	logic [19:0] over_q;
	logic [20:0] exp_e_q;
	logic [16:0] y_q;
	logic [28:0] res_q;
	acng_pkg::q23_t env_mem_q [acng_pkg::CHANNELS];
	acng_pkg::q23_t gain_mem_q [acng_pkg::CHANNELS];
	logic        out_valid_q;
	logic [23:0] sample_out_q;
	logic [2:0]  channel_out_q;
	logic        block_end_out_q;

	logic [acng_pkg::MUL_A_W-1:0] mul_a;
	logic [acng_pkg::MUL_B_W-1:0] mul_b;
	logic [acng_pkg::CH_IDX_W-1:0] ch_idx, in_idx;
	logic        in_range;
	logic [23:0] in_raw, in_mag;
	logic [16:0] coef_inv;
	logic [40:0] op_sum;
	acng_pkg::q23_t op_new;
	logic [12:0] corr;
	logic [19:0] lvl_pos;
	logic [20:0] lvl_neg;
	logic [36:0] ovr_round;
	logic [15:0] exp_fr;
	logic [16:0] exp_y;
	logic [17:0] exp_m;
	logic [23:0] exp_mm, exp_res;
	logic [10:0] gate_e;
	logic        gt_target;
	logic [48:0] a_sum;
	logic [57:0] r_sum;
	logic [28:0] sat_mag;
	logic [23:0] sat_val;
	logic        out_free;

	assign in_ready = (state_q == S_IDLE) && !div_busy_q;
	assign out_valid = out_valid_q;
	assign sample_out = $signed(sample_out_q);
	assign channel_out = channel_out_q;
	assign block_end_out = block_end_out_q;

	assign ch_idx   = acng_pkg::CH_IDX_W'(ch_q);
	assign in_idx   = acng_pkg::CH_IDX_W'(channel);
	assign in_range = (32'(channel) < 32'(acng_pkg::CHANNELS));
	assign in_raw   = $unsigned(sample_in);
	assign in_mag   = in_raw[23] ? (24'd0 - in_raw) : in_raw;

	assign coef_inv = 17'd65536 - {1'b0, coef_q};
	assign op_sum   = acc_q + prod_q[40:0] + 41'd32768;
	assign op_new   = op_sum[39:16];

	assign corr    = prod_q[44:32];
	assign lvl_pos = 20'(f_q) + 20'(corr) + 20'(thr_q);
	assign lvl_neg = {sh_q, 16'd0};
	assign ovr_round = prod_q[36:0] + 37'd32768;

	assign exp_fr  = exp_e_q[15:0];
	assign exp_y   = 17'd65536 - {1'b0, exp_fr};
	assign exp_m   = 18'd65536 + 18'(y_q) - 18'(prod_q[44:32]);
	assign exp_mm  = {exp_m, 6'd0};
	assign exp_res = (i_q >= 5'd24) ? 24'd0 : (exp_mm >> i_q);

	assign gate_e = gate_thr_q[10] ? (11'd0 - $unsigned(gate_thr_q)) : 11'd0;

	always_comb begin
		gt_target = (gain_w_q >= acng_pkg::HALF_Q23);
		if (env_w_q >= tgt_q) gt_target = 1'b1;
		if (env_w_q < (tgt_q >> 1)) gt_target = 1'b0;
	end

	assign a_sum = 49'(prod_q[47:0]) + 49'(24'h400000);
	assign r_sum = 58'(prod_q) + 58'(28'h8000000);

	always_comb begin
		if (neg_q) sat_mag = (res_q > 29'(acng_pkg::ONE_Q23)) ? 29'(acng_pkg::ONE_Q23) : res_q;
		else sat_mag = (res_q > 29'(acng_pkg::MAX_POS_Q23)) ? 29'(acng_pkg::MAX_POS_Q23) : res_q;
		sat_val = neg_q ? (24'd0 - sat_mag[23:0]) : sat_mag[23:0];
	end

	assign out_free = !out_valid_q || out_ready;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_E1: begin mul_a = 33'(coef_q); mul_b = env_w_q; end
			S_E2: begin mul_a = 33'(coef_inv); mul_b = mag_q; end
			S_E3: begin mul_a = 33'(acng_pkg::THR_SPAN_Q16); mul_b = 24'(sustain_q); end
			S_L1: begin mul_a = 33'(f_q); mul_b = 24'(17'd65536 - {1'b0, f_q}); end
			S_L2: begin mul_a = prod_q[32:0]; mul_b = 24'(acng_pkg::LOG_CORR); end
			S_O1: begin mul_a = 33'(over_q); mul_b = 24'(slope_q); end
			S_GA1: begin mul_a = 33'(acng_pkg::TENTH_DB_TO_LOG2); mul_b = 24'(gate_e); end
			S_XA: begin mul_a = 33'(exp_y); mul_b = 24'(exp_fr); end
			S_XB: begin mul_a = prod_q[32:0]; mul_b = 24'(acng_pkg::EXP_CORR); end
			S_G1: begin mul_a = 33'(coef_q); mul_b = gain_w_q; end
			S_G2: begin mul_a = 33'(coef_inv); mul_b = tgt_q; end
			S_M1: begin mul_a = 33'(mag_q); mul_b = gain_w_q; end
			S_M2: begin mul_a = 33'(17'd65536 + {1'b0, sustain_q}); mul_b = 24'(makeup_q); end
			S_M3: begin mul_a = prod_q[32:0]; mul_b = a_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			comp_atk_q <= 16'd65262;
			comp_rel_q <= 16'd65528;
			gate_atk_q <= 16'd64177;
			gate_rel_q <= 16'd65399;
			sustain_q  <= 16'd32768;
			makeup_q   <= 16'd4096;
			gate_thr_q <= -11'sd600;
		end else if (cfg_we) begin
			case (cfg_index)
				acng_pkg::CFG_MODE:     mode_q     <= cfg_wdata[0];
				acng_pkg::CFG_COMP_ATK: comp_atk_q <= cfg_wdata;
				acng_pkg::CFG_COMP_REL: comp_rel_q <= cfg_wdata;
				acng_pkg::CFG_GATE_ATK: gate_atk_q <= cfg_wdata;
				acng_pkg::CFG_GATE_REL: gate_rel_q <= cfg_wdata;
				acng_pkg::CFG_SUSTAIN:  sustain_q  <= cfg_wdata;
				acng_pkg::CFG_MAKEUP:   makeup_q   <= cfg_wdata;
				acng_pkg::CFG_GATE_THR: gate_thr_q <= $signed(cfg_wdata[10:0]);
				default: ;
			endcase
		end
	end

	// slope = 65536 - 2^32 / (131072 + 6*sustain), restoring, one bit a cycle
	assign div_r2     = {div_r_q[18:0], 1'b0};
	assign div_ge     = (div_r2 >= {1'b0, div_d_q});
	assign div_q_next = {div_q_q[14:0], div_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_r_q    <= '0;
			div_d_q    <= '0;
			div_q_q    <= '0;
			div_cnt_q  <= '0;
			slope_q    <= acng_pkg::SLOPE_RESET;
		end else if (cfg_we && (cfg_index == acng_pkg::CFG_SUSTAIN)) begin
			div_busy_q <= 1'b1;
			div_d_q    <= acng_pkg::DIV_BASE + {1'b0, cfg_wdata, 2'b00} + {2'b00, cfg_wdata, 1'b0};
			div_r_q    <= 20'd65536;
			div_q_q    <= '0;
			div_cnt_q  <= 5'd16;
		end else if (div_busy_q) begin
			div_r_q   <= div_ge ? (div_r2 - {1'b0, div_d_q}) : div_r2;
			div_q_q   <= div_q_next;
			div_cnt_q <= div_cnt_q - 5'd1;
			if (div_cnt_q == 5'd1) begin
				div_busy_q <= 1'b0;
				slope_q    <= 17'd65536 - {1'b0, div_q_next};
			end
		end
	end

	// sequencer, per-channel state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ch_q <= '0; raw_q <= '0; mag_q <= '0; neg_q <= 1'b0; be_q <= 1'b0; pass_q <= 1'b0;
			env_w_q <= '0; gain_w_q <= '0; tgt_q <= '0; a_q <= '0; x_q <= '0;
			coef_q <= '0; f_q <= '0; acc_q <= '0; prod_q <= '0; sh_q <= '0; i_q <= '0;
			thr_q <= '0; over_q <= '0; exp_e_q <= '0; y_q <= '0; res_q <= '0;
			for (int k = 0; k < acng_pkg::CHANNELS; k++) begin
				env_mem_q[k]  <= '0;
				gain_mem_q[k] <= acng_pkg::ONE_Q23;
			end
			out_valid_q <= 1'b0;
			sample_out_q <= '0;
			channel_out_q <= '0;
			block_end_out_q <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (out_valid_q && out_ready && (state_q != S_DONE)) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						ch_q   <= channel;
						raw_q  <= in_raw;
						mag_q  <= in_mag;
						neg_q  <= in_raw[23];
						be_q   <= block_end;
						pass_q <= !in_range;
						if (in_range) begin
							env_w_q  <= env_mem_q[in_idx];
							gain_w_q <= gain_mem_q[in_idx];
							if (mode_q) coef_q <= (in_mag > env_mem_q[in_idx]) ? gate_atk_q : gate_rel_q;
							else coef_q <= (in_mag > env_mem_q[in_idx]) ? comp_atk_q : comp_rel_q;
							state_q <= S_E1;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: begin
					acc_q   <= prod_q[40:0];
					state_q <= S_E3;
				end
				S_E3: begin
					env_w_q <= op_new;
					env_mem_q[ch_idx] <= op_new;
					x_q     <= op_new + acng_pkg::ENV_EPS;
					sh_q    <= '0;
					coef_q  <= comp_atk_q;
					state_q <= mode_q ? S_GA1 : S_N16;
				end
				S_N16: begin
					thr_q <= acng_pkg::THR_BASE_Q16 + prod_q[34:16];
					if (x_q[23:8] == '0) begin
						x_q <= {x_q[7:0], 16'd0};
						sh_q <= sh_q + 5'd16;
					end
					state_q <= S_N8;
				end
				S_N8: begin
					if (x_q[23:16] == '0) begin
						x_q <= {x_q[15:0], 8'd0};
						sh_q <= sh_q + 5'd8;
					end
					state_q <= S_N4;
				end
				S_N4: begin
					if (x_q[23:20] == '0) begin
						x_q <= {x_q[19:0], 4'd0};
						sh_q <= sh_q + 5'd4;
					end
					state_q <= S_N2;
				end
				S_N2: begin
					if (x_q[23:22] == '0) begin
						x_q <= {x_q[21:0], 2'd0};
						sh_q <= sh_q + 5'd2;
					end
					state_q <= S_N1;
				end
				S_N1: begin
					if (!x_q[23]) begin
						x_q <= {x_q[22:0], 1'b0};
						sh_q <= sh_q + 5'd1;
						f_q <= x_q[21:6];
					end else begin
						f_q <= x_q[22:7];
					end
					state_q <= S_L1;
				end
				S_L1: state_q <= S_L2;
				S_L2: state_q <= S_L3;
				S_L3: begin
					if ({1'b0, lvl_pos} > lvl_neg) begin
						over_q  <= lvl_pos - lvl_neg[19:0];
						state_q <= S_O1;
					end else begin
						tgt_q   <= acng_pkg::ONE_Q23;
						state_q <= S_G1;
					end
				end
				S_O1: state_q <= S_O2;
				S_O2: begin
					exp_e_q <= ovr_round[36:16];
					state_q <= S_XA;
				end
				S_GA1: state_q <= S_GA2;
				S_GA2: begin
					exp_e_q <= prod_q[30:10];
					state_q <= S_XA;
				end
				S_XA: begin
					y_q <= exp_y;
					i_q <= exp_e_q[20:16];
					state_q <= S_XB;
				end
				S_XB: state_q <= S_XC;
				S_XC: begin
					tgt_q   <= exp_res;
					state_q <= mode_q ? S_GT : S_G1;
				end
				S_GT: begin
					// tgt_q holds the open level here
					tgt_q  <= gt_target ? acng_pkg::ONE_Q23 : 24'd0;
					coef_q <= (gt_target && (acng_pkg::ONE_Q23 > gain_w_q)) ? gate_atk_q
						: gate_rel_q;
					state_q <= S_G1;
				end
				S_G1: state_q <= S_G2;
				S_G2: begin
					acc_q   <= prod_q[40:0];
					state_q <= S_G3;
				end
				S_G3: begin
					gain_w_q <= op_new;
					gain_mem_q[ch_idx] <= op_new;
					state_q <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					a_q <= a_sum[46:23];
					if (mode_q) begin
						res_q   <= 29'(a_sum[46:23]);
						state_q <= S_DONE;
					end else begin
						state_q <= S_M3;
					end
				end
				S_M3: state_q <= S_M4;
				S_M4: begin
					res_q   <= r_sum[56:28];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q     <= 1'b1;
						sample_out_q    <= pass_q ? raw_q : sat_val;
						channel_out_q   <= ch_q;
						block_end_out_q <= be_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ACNG_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && in_ready, !in_ready)
	`ACNG_ASSERT(a_no_take_while_div, clk, arst_n, div_busy_q |-> !in_ready)
	`ACNG_ASSERT_NEXT(a_done_holds, clk, arst_n,
		(state_q == S_DONE) && out_valid_q && !out_ready, state_q == S_DONE)
	`ACNG_ASSERT_NEXT(a_done_loads_out, clk, arst_n,
		(state_q == S_DONE) && out_free, out_valid_q && (state_q == S_IDLE))
endmodule
`default_nettype wire
